// ===== rtl/mgm_pkg.sv =====
package mgm_pkg;

	localparam int unsigned NumRounds = 32;
	localparam int unsigned KeyWords  = 8;
	localparam int unsigned KeyIdxW   = $clog2(KeyWords);
	localparam int unsigned RoundIdxW = $clog2(NumRounds);
	localparam int unsigned RotLeft   = 11;
	localparam int unsigned RotRight  = 21;

	localparam logic OpEncrypt = 1'b0;
	localparam logic OpDecrypt = 1'b1;

	// row 0 serves the top nibble
	localparam logic [3:0] Sbox [8][16] = '{
		'{4'd1, 4'd7, 4'd14, 4'd13, 4'd0, 4'd5, 4'd8, 4'd3,
		  4'd4, 4'd15, 4'd10, 4'd6, 4'd9, 4'd12, 4'd11, 4'd2},
		'{4'd8, 4'd14, 4'd2, 4'd5, 4'd6, 4'd9, 4'd1, 4'd12,
		  4'd15, 4'd4, 4'd11, 4'd0, 4'd13, 4'd10, 4'd3, 4'd7},
		'{4'd5, 4'd13, 4'd15, 4'd6, 4'd9, 4'd2, 4'd12, 4'd10,
		  4'd11, 4'd7, 4'd8, 4'd1, 4'd4, 4'd3, 4'd14, 4'd0},
		'{4'd7, 4'd15, 4'd5, 4'd10, 4'd8, 4'd1, 4'd6, 4'd13,
		  4'd0, 4'd9, 4'd3, 4'd14, 4'd11, 4'd4, 4'd2, 4'd12},
		'{4'd12, 4'd8, 4'd2, 4'd1, 4'd13, 4'd4, 4'd15, 4'd6,
		  4'd7, 4'd0, 4'd10, 4'd5, 4'd3, 4'd14, 4'd9, 4'd11},
		'{4'd11, 4'd3, 4'd5, 4'd8, 4'd2, 4'd15, 4'd10, 4'd13,
		  4'd14, 4'd1, 4'd7, 4'd4, 4'd12, 4'd9, 4'd6, 4'd0},
		'{4'd6, 4'd8, 4'd2, 4'd3, 4'd9, 4'd10, 4'd5, 4'd12,
		  4'd1, 4'd14, 4'd4, 4'd7, 4'd11, 4'd13, 4'd0, 4'd15},
		'{4'd12, 4'd4, 4'd6, 4'd2, 4'd10, 4'd5, 4'd11, 4'd9,
		  4'd14, 4'd8, 4'd13, 4'd7, 4'd0, 4'd3, 4'd15, 4'd1}
	};

	typedef struct packed {
		logic        op;
		logic [31:0] l;
		logic [31:0] r;
	} stage_t;

	// key word used by encryption round r
	function automatic logic [KeyIdxW-1:0] key_idx(input logic [RoundIdxW-1:0] r);
		if (r < RoundIdxW'(NumRounds - KeyWords))
			return r[KeyIdxW-1:0];
		else
			return ~r[KeyIdxW-1:0];
	endfunction

	function automatic logic [31:0] mix(input logic [31:0] half, input logic [31:0] k);
		logic [31:0] s;
		logic [31:0] t;
		s = half + k;
		for (int j = 0; j < 8; j++) begin
			t[4*j +: 4] = Sbox[7-j][s[4*j +: 4]];
		end
		return {t[31-RotLeft:0], t[31:RotRight]};
	endfunction

endpackage

// ===== rtl/mgm_round_cell.sv =====
module mgm_round_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            up_valid,
	output logic            up_ready,
	input  mgm_pkg::stage_t up_data,
	input  logic [31:0]     key_enc,
	input  logic [31:0]     key_dec,
	output logic            dn_valid,
	input  logic            dn_ready,
	output mgm_pkg::stage_t dn_data
);
	import mgm_pkg::*;

	logic        valid_q;
	stage_t      data_q;
	logic [31:0] rkey;
	stage_t      nxt;

	assign up_ready = !valid_q || dn_ready;
	assign rkey     = (up_data.op == OpDecrypt) ? key_dec : key_enc;

	always_comb begin
		nxt.op = up_data.op;
		nxt.l  = up_data.r;
		nxt.r  = up_data.l ^ mix(up_data.r, rkey);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_q <= nxt;
		end
	end

	assign dn_valid = valid_q;
	assign dn_data  = data_q;

endmodule

// ===== rtl/magma_block_cipher.sv =====
// channel   signals                                  moves
// input     in_valid/in_ready, opcode, block_in      one block request
// output    out_valid/out_ready, block_out           one processed block
// config    cfg_we, cfg_index, cfg_data              key word write
//
// 32 round cells in a row.
// One block is accepted per cycle when the output keeps draining.
// Each cell stalls only when full and its successor is stalled, so bubbles fill.
// Reset clears the cell valid bits and sets the key to all zero.
module magma_block_cipher (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        opcode,
	input  logic [63:0]                 block_in,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [63:0]                 block_out,
	input  logic                        cfg_we,
	input  logic [mgm_pkg::KeyIdxW-1:0] cfg_index,
	input  logic [31:0]                 cfg_data
);
	import mgm_pkg::*;

	logic [31:0] key_q [KeyWords];
	logic        vld   [NumRounds+1];
	logic        rdy   [NumRounds+1];
	stage_t      dat   [NumRounds+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < KeyWords; i++) begin
				key_q[i] <= '0;
			end
		end else if (cfg_we) begin
			key_q[cfg_index] <= cfg_data;
		end
	end

	assign vld[0]    = in_valid;
	assign in_ready  = rdy[0];
	assign dat[0].op = opcode;
	assign dat[0].l  = block_in[63:32];
	assign dat[0].r  = block_in[31:0];

	for (genvar i = 0; i < NumRounds; i++) begin : g_cell
		mgm_round_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (vld[i]),
			.up_ready (rdy[i]),
			.up_data  (dat[i]),
			.key_enc  (key_q[key_idx(RoundIdxW'(i))]),
			.key_dec  (key_q[key_idx(RoundIdxW'(NumRounds - 1 - i))]),
			.dn_valid (vld[i+1]),
			.dn_ready (rdy[i+1]),
			.dn_data  (dat[i+1])
		);
	end

	// every cell swaps; the last round must not, so swap back here
	assign out_valid        = vld[NumRounds];
	assign rdy[NumRounds]   = out_ready;
	assign block_out        = {dat[NumRounds].r, dat[NumRounds].l};

endmodule
